[hdl/crc16_frame_receive_checker_defines.svh]
// assertion macros for the crc16 frame receive checker
`ifndef CRC16_FRAME_RECEIVE_CHECKER_DEFINES_SVH
`define CRC16_FRAME_RECEIVE_CHECKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CRC16FRC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("crc16frc check failed");

// next-cycle implication, sampled on clk, off while in reset
`define CRC16FRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("crc16frc check failed");

`endif

[hdl/crc16frc_pkg.sv]
// types, constants and crc byte update for the crc16 frame receive checker
package crc16frc_pkg;

	localparam int          BUFFER_BYTES_DEF = 256;
	localparam logic [15:0] CRC_INIT         = 16'hFFFF;
	localparam logic [15:0] CRC_POLY         = 16'hA001;
	localparam int          MIN_FRAME        = 6;
	localparam int          TAIL_LEN         = 3;

	// byte positions captured from the frame head
	localparam int POS_USER_ID   = 1;
	localparam int POS_FRAME_NUM = 2;
	localparam int POS_LEN_LO    = 3;
	localparam int POS_LEN_HI    = 4;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_END  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SHORT    = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_OVERRUN  = 2'd3
	} status_t;

	// one byte through reflected crc-16, lsb first
	function automatic logic [15:0] crc_absorb(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

[hdl/crc16_frame_receive_checker.sv]
// crc16 frame receive checker: byte intake, crc over the frame body, end of frame status
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------------------
//  request  | req_valid / req_ready  | operation, rx_byte
//  result   | rsp_valid / rsp_ready  | frame_status, user_id, seq_num, data_length,
//           |                        | byte_count
//
// one request per clock, save the stall below: a byte request is captured in the input
// stage and retired the next cycle by a crc byte update (eight unrolled shift/xor steps)
// end of frame loads the result register when the request leaves the input stage
// the result register parts the two sides; the input stalls only while an end-of-frame
// request sits in the input stage and an earlier result is still held and not taken
// asynchronous reset clears all frame state; no clearing pass
module crc16_frame_receive_checker
	import crc16frc_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	localparam int CNT_W = $clog2(BUFFER_BYTES + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             req_valid,
	output logic             req_ready,
	input  logic             operation,
	input  logic [7:0]       rx_byte,
	// result channel
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [1:0]       frame_status,
	output logic [7:0]       user_id,
	output logic [7:0]       seq_num,
	output logic [15:0]      data_length,
	output logic [CNT_W-1:0] byte_count
);

`include "crc16_frame_receive_checker_defines.svh"

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_BYTES);
	localparam logic [CNT_W-1:0] CNT_MIN  = CNT_W'(MIN_FRAME);

	// input stage
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] byte_s1;

	// frame state
	logic [15:0]      crc_q;
	logic [7:0]       tail_q [TAIL_LEN];
	logic [CNT_W-1:0] count_q;
	logic             overrun_q;
	logic [7:0]       id_q;
	logic [7:0]       num_q;
	logic [15:0]      len_q;

	// result register
	logic             rsp_valid_q;
	status_t          status_q;
	logic [7:0]       user_id_q;
	logic [7:0]       seq_num_q;
	logic [15:0]      data_length_q;
	logic [CNT_W-1:0] byte_count_q;

	logic    s1_adv;
	logic    s1_fire;
	logic    end_fire;
	logic    byte_fire;
	logic    full;
	logic    crc_match;
	status_t status_d;

	// a byte request never waits; end of frame waits for a free result register
	assign s1_adv    = (op_s1 == OP_BYTE) || !rsp_valid_q || rsp_ready;
	assign s1_fire   = valid_s1 && s1_adv;
	assign end_fire  = s1_fire && (op_s1 == OP_END);
	assign byte_fire = s1_fire && (op_s1 == OP_BYTE);
	assign req_ready = !valid_s1 || s1_adv;

	assign full      = (count_q == CNT_FULL);
	assign crc_match = (tail_q[2] == crc_q[15:8]) && (tail_q[1] == crc_q[7:0]);

	// overrun first, then too short, then check compare
	always_comb begin
		if (overrun_q) begin
			status_d = ST_OVERRUN;
		end else if (count_q < CNT_MIN) begin
			status_d = ST_SHORT;
		end else if (crc_match) begin
			status_d = ST_OK;
		end else begin
			status_d = ST_MISMATCH;
		end
	end

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			op_s1    <= OP_BYTE;
			byte_s1  <= '0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
			if (req_valid) begin
				op_s1   <= op_t'(operation);
				byte_s1 <= rx_byte;
			end
		end
	end

	// frame state: byte intake and clear after end of frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_INIT;
			tail_q    <= '{default: '0};
			count_q   <= '0;
			overrun_q <= 1'b0;
			id_q      <= '0;
			num_q     <= '0;
			len_q     <= '0;
		end else if (end_fire) begin
			crc_q     <= CRC_INIT;
			tail_q    <= '{default: '0};
			count_q   <= '0;
			overrun_q <= 1'b0;
			id_q      <= '0;
			num_q     <= '0;
			len_q     <= '0;
		end else if (byte_fire) begin
			if (full) begin
				// buffer full: byte dropped, frame marked overrun
				overrun_q <= 1'b1;
			end else begin
				// crc trails the input by the three-byte delay line
				if (count_q >= CNT_W'(TAIL_LEN)) begin
					crc_q <= crc_absorb(crc_q, tail_q[2]);
				end
				tail_q[2] <= tail_q[1];
				tail_q[1] <= tail_q[0];
				tail_q[0] <= byte_s1;
				if (count_q == CNT_W'(POS_USER_ID)) begin
					id_q <= byte_s1;
				end
				if (count_q == CNT_W'(POS_FRAME_NUM)) begin
					num_q <= byte_s1;
				end
				if (count_q == CNT_W'(POS_LEN_LO)) begin
					len_q[7:0] <= byte_s1;
				end
				if (count_q == CNT_W'(POS_LEN_HI)) begin
					len_q[15:8] <= byte_s1;
				end
				count_q <= count_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (end_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (end_fire) begin
			status_q      <= status_d;
			user_id_q     <= id_q;
			seq_num_q     <= num_q;
			data_length_q <= len_q;
			byte_count_q  <= count_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign frame_status = status_q;
	assign user_id      = user_id_q;
	assign seq_num      = seq_num_q;
	assign data_length  = data_length_q;
	assign byte_count   = byte_count_q;

	// byte count never passes the buffer size
	`CRC16FRC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_FULL)
	// end of frame leaves a cleared frame behind
	`CRC16FRC_ASSERT_NEXT(a_clear, end_fire, count_q == '0 && crc_q == CRC_INIT && !overrun_q)
	// overrun only ever reported on a full buffer
	`CRC16FRC_ASSERT_NOW(a_ovr_full, rsp_valid_q && status_q == ST_OVERRUN, byte_count_q == CNT_FULL)
	// a good frame is never shorter than the minimum
	`CRC16FRC_ASSERT_NOW(a_ok_len, rsp_valid_q && status_q == ST_OK, byte_count_q >= CNT_MIN)

endmodule
